### sv/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// Types and codes shared by the priority ring deque modules.
// ----------------------------------------------------------------------------
package prd_pkg;

  localparam int OCC_W = 6;
  localparam int LEN_W = 14;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [2:0] ST_QUEUED  = 3'd0;
  localparam logic [2:0] ST_EVICTED = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_POPPED  = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic             opcode;
    logic [31:0]      sender_uid;
    logic [31:0]      msg_type;
    logic [LEN_W-1:0] payload_len;
    logic [15:0]      payload_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [31:0]      out_uid;
    logic [31:0]      out_type;
    logic [LEN_W-1:0] out_len;
    logic [15:0]      out_tag;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic [31:0]      uid;
    logic [31:0]      msg_type;
    logic [LEN_W-1:0] len;
    logic [15:0]      tag;
  } slot_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [OCC_W-1:0] occupancy;
  } pend_t;

endpackage

### sv/prd_ram.sv
// ----------------------------------------------------------------------------
// prd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module prd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/prd_ctl.sv
// ----------------------------------------------------------------------------
// prd_ctl
// Head and tail pointers, placement decision and slot memory requests.
// ----------------------------------------------------------------------------
module prd_ctl
  import prd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_PAYLOAD = 8192
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  in_item_t                       item,
  input  logic [31:0]                    bulk_type_code,
  input  logic                           advance,
  output logic                           pend_valid,
  output pend_t                          pend,
  output logic                           ram_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
  output slot_t                          ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FW    = (PTR_W + 1 > OCC_W) ? PTR_W + 1 : OCC_W;
  localparam int CAP   = (MAX_PAYLOAD > 16383) ? 16383 : MAX_PAYLOAD;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP);

  logic [PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  pend_t            pend_r, pend_nxt;
  logic [PTR_W-1:0] head_dec, tail_dec, tail_inc, head_inc;
  logic [FW-1:0]    fill;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST : p - 1'b1;
  endfunction

  assign head_dec = ptr_dec(head_r);
  assign head_inc = ptr_inc(head_r);
  assign tail_dec = ptr_dec(tail_r);
  assign tail_inc = ptr_inc(tail_r);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    ram_we     = 1'b0;
    ram_waddr  = tail_r;
    ram_re     = 1'b0;
    ram_raddr  = head_r;
    pend_nxt   = pend_r;
    ram_wdata.uid      = item.sender_uid;
    ram_wdata.msg_type = item.msg_type;
    ram_wdata.len      = (item.payload_len > LEN_CAP) ? LEN_CAP : item.payload_len;
    ram_wdata.tag      = item.payload_tag;
    pend_nxt.status    = ST_QUEUED;
    if (accept) begin
      if (item.opcode == OP_POP) begin
        if (head_r == tail_r) begin
          pend_nxt.status = ST_EMPTY;
        end else begin
          ram_re          = 1'b1;
          head_nxt        = head_inc;
          pend_nxt.status = ST_POPPED;
        end
      end else if (item.msg_type != bulk_type_code) begin
        // urgent entry goes in front of the head, evicting the newest if full
        head_nxt  = head_dec;
        ram_we    = 1'b1;
        ram_waddr = head_dec;
        if (head_dec == tail_r) begin
          tail_nxt        = tail_dec;
          pend_nxt.status = ST_EVICTED;
        end
      end else begin
        if (tail_inc == head_r) begin
          pend_nxt.status = ST_DROPPED;
        end else begin
          ram_we   = 1'b1;
          tail_nxt = tail_inc;
        end
      end
    end
    if (tail_nxt >= head_nxt) begin
      fill = FW'({1'b0, tail_nxt}) - FW'({1'b0, head_nxt});
    end else begin
      fill = FW'({1'b0, tail_nxt}) + FW'(QUEUE_DEPTH) - FW'({1'b0, head_nxt});
    end
    pend_nxt.occupancy = fill[OCC_W-1:0];
    if (!accept) begin
      pend_nxt = pend_r;
    end
    pend_valid_nxt = accept ? 1'b1 : (advance ? 1'b0 : pend_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
    pend_r <= pend_nxt;
  end

  assign pend_valid = pend_valid_r;
  assign pend       = pend_r;

endmodule

### sv/priority_ring_deque_core.sv
// ----------------------------------------------------------------------------
// priority_ring_deque_core
// Circular descriptor queue: urgent pushes enter at the head, bulk at the tail.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one push or pop per
// transaction; every transaction gives exactly one result on
// out_valid/out_stall/out_data. The queue holds at most QUEUE_DEPTH-1 entries.
// The user must write the bulk message type via cfg_valid/cfg_ready/cfg_data
// only while idle; the block does not enforce this. cfg_ready is always high.
// From accept to out_valid the slot RAM read and pending stage are registered,
// then the result is registered in the output register. Pointer updates finish
// in the accept cycle, so one transaction per cycle is sustained while out_stall
// is low; the slot RAM single read port and the one pending stage set that figure.
// When out_stall holds a finished result, one more transaction is taken into
// the pending stage, then in_stall rises until the output register drains.
// Synchronous reset (rst_n low) empties the queue and clears the bulk type
// to zero; the slot RAM contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module priority_ring_deque_core
  import prd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_PAYLOAD = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [31:0]      bulk_r, bulk_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             accept, advance, out_free;
  logic             pend_valid;
  pend_t            pend;
  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  slot_t            ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = pend_valid && out_free;
  assign in_stall  = pend_valid && !out_free;
  assign accept    = in_valid && !in_stall;

  prd_ctl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_ctl (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .item           (in_data),
    .bulk_type_code (bulk_r),
    .advance        (advance),
    .pend_valid     (pend_valid),
    .pend           (pend),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr)
  );

  prd_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    bulk_nxt      = cfg_valid ? cfg_data : bulk_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.status    = pend.status;
      out_data_nxt.occupancy = pend.occupancy;
      // descriptor fields only for a real pop
      if (pend.status == ST_POPPED) begin
        out_data_nxt.out_uid  = ram_rdata.uid;
        out_data_nxt.out_type = ram_rdata.msg_type;
        out_data_nxt.out_len  = ram_rdata.len;
        out_data_nxt.out_tag  = ram_rdata.tag;
      end else begin
        out_data_nxt.out_uid  = '0;
        out_data_nxt.out_type = '0;
        out_data_nxt.out_len  = '0;
        out_data_nxt.out_tag  = '0;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bulk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bulk_r      <= bulk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the priority ring deque core.
// Urgent and bulk pushes and pops are driven through the stall handshake,
// and the bulk type changes between phases. A scoreboard keeps its own copy
// of the ring and compares every result field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prd_pkg::*;

  localparam int QDEPTH       = 64;
  localparam int MAXPL        = 8192;
  localparam int IDLE_PCT     = 18;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SETTLE       = 4;
  localparam int HOLD_CYCLES  = 200;

  class deque_scoreboard;
    logic [31:0] bulk_code;
    int          head;
    int          tail;
    slot_t       ring[QDEPTH];
    out_item_t   awaited_outcomes[$];
    int          errors;

    function new();
      bulk_code = '0;
      head      = 0;
      tail      = 0;
      errors    = 0;
    endfunction

    function int outstanding();
      return awaited_outcomes.size();
    endfunction

    // ring model: urgent goes in ahead of head, bulk behind tail
    function void note_request(in_item_t req);
      out_item_t        res;
      slot_t            entry;
      logic [LEN_W-1:0] stored_len;
      res        = '0;
      stored_len = (req.payload_len > MAXPL) ? LEN_W'(MAXPL) : req.payload_len;
      entry      = '{uid: req.sender_uid, msg_type: req.msg_type,
                     len: stored_len, tag: req.payload_tag};
      if (req.opcode == OP_POP) begin
        if (head == tail) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_uid  = ring[head].uid;
          res.out_type = ring[head].msg_type;
          res.out_len  = ring[head].len;
          res.out_tag  = ring[head].tag;
          head         = (head + 1) % QDEPTH;
          res.status   = ST_POPPED;
        end
      end else if (req.msg_type != bulk_code) begin
        head       = (head + QDEPTH - 1) % QDEPTH;
        res.status = ST_QUEUED;
        if (head == tail) begin
          // full: newest tail entry makes room
          tail       = (tail + QDEPTH - 1) % QDEPTH;
          res.status = ST_EVICTED;
        end
        ring[head] = entry;
      end else if ((tail + 1) % QDEPTH == head) begin
        res.status = ST_DROPPED;
      end else begin
        ring[tail] = entry;
        tail       = (tail + 1) % QDEPTH;
        res.status = ST_QUEUED;
      end
      res.occupancy = OCC_W'((tail + QDEPTH - head) % QDEPTH);
      awaited_outcomes.push_back(res);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_outcome(out_item_t got);
      out_item_t want;
      if (awaited_outcomes.size() == 0) begin
        $error("result with no transaction outstanding: %0h", got);
        errors++;
        return;
      end
      want = awaited_outcomes.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("out_uid", want.out_uid, got.out_uid);
      check_field("out_type", want.out_type, got.out_type);
      check_field("out_len", 32'(want.out_len), 32'(got.out_len));
      check_field("out_tag", 32'(want.out_tag), 32'(got.out_tag));
      check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
    endfunction
  endclass

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = '0;

  deque_scoreboard sb = new();
  bit              calm = 1'b0;
  logic [31:0]     bulk_now = '0;
  int              results_seen = 0;

  priority_ring_deque_core #(
    .QUEUE_DEPTH(QDEPTH),
    .MAX_PAYLOAD(MAXPL)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_item_t mk(logic op, logic [31:0] uid, logic [31:0] mtype,
                                  logic [LEN_W-1:0] len, logic [15:0] tag);
    in_item_t req;
    req = '{opcode: op, sender_uid: uid, msg_type: mtype,
            payload_len: len, payload_tag: tag};
    return req;
  endfunction

  task automatic send_item(input in_item_t req);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
  endtask

  // only while nothing is in flight
  task automatic write_bulk_type(input logic [31:0] code);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    sb.bulk_code = code;
    bulk_now     = code;
  endtask

  // result side: random stalls plus long hold-offs while the sender keeps going
  initial begin
    int hold_left;
    int hold_runs;
    hold_left = 0;
    hold_runs = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_outcome(out_data);
        results_seen++;
      end
      if (hold_left == 0 && hold_runs < 2 && in_valid &&
          results_seen >= 400 + 600 * hold_runs) begin
        hold_left = HOLD_CYCLES;
        hold_runs++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $error("no transaction for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    in_item_t    plan[$];
    in_item_t    req;
    logic [31:0] phase_codes[7];
    int          push_pct[7];
    int          pick;

    phase_codes = '{32'h0000_0000, $urandom, 32'hFFFF_FFFF, 32'($urandom_range(7)),
                    $urandom, 32'h0000_0000, 32'hFFFF_FFFF};
    push_pct    = '{85, 20, 50, 85, 50, 15, 85};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bulk type is zero out of reset
    plan = '{mk(OP_POP, '0, '0, '0, '0),
             mk(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14'h3FFF, 16'hFFFF),
             mk(OP_PUSH, '0, '0, '0, '0),
             mk(OP_PUSH, 32'h1234_5678, 32'h0000_0001, 14'd8192, 16'h0001),
             mk(OP_PUSH, 32'h8000_0000, 32'h8000_0000, 14'd8193, 16'h8000),
             mk(OP_PUSH, 32'hAAAA_5555, '0, 14'd8191, 16'h5555),
             mk(OP_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14'h3FFF, 16'hFFFF),
             mk(OP_POP, '0, '0, '0, '0),
             mk(OP_POP, '0, '0, '0, '0),
             mk(OP_POP, '0, '0, '0, '0),
             mk(OP_POP, '0, '0, '0, '0),
             mk(OP_POP, '0, '0, '0, '0)};
    foreach (plan[i]) send_item(plan[i]);

    write_bulk_type(32'hFFFF_FFFF);
    plan = '{mk(OP_PUSH, 32'h0000_0001, 32'hFFFF_FFFF, 14'd100, 16'h00FF),
             mk(OP_PUSH, 32'h0000_0002, 32'h0000_0000, 14'd0, 16'hFF00),
             mk(OP_PUSH, 32'h0000_0003, 32'hFFFF_FFFE, 14'h3FFF, 16'h0000),
             mk(OP_POP, '0, '0, '0, '0),
             mk(OP_POP, '0, '0, '0, '0),
             mk(OP_POP, '0, '0, '0, '0),
             mk(OP_POP, '0, '0, '0, '0)};
    foreach (plan[i]) send_item(plan[i]);

    // phases vary the push mix; the fill-heavy ones drive drops and evictions
    for (int ph = 0; ph < 7; ph++) begin
      write_bulk_type(phase_codes[ph]);
      calm = (ph == 4);
      for (int n = 0; n < 190; n++) begin
        req.opcode     = ($urandom_range(99) < push_pct[ph]) ? OP_PUSH : OP_POP;
        req.sender_uid = $urandom;
        pick = $urandom_range(99);
        if (pick < 45)
          req.msg_type = bulk_now;
        else if (pick < 55)
          req.msg_type = bulk_now ^ (32'h1 << $urandom_range(31));
        else
          req.msg_type = $urandom;
        pick = $urandom_range(99);
        if (pick < 60)
          req.payload_len = LEN_W'($urandom_range(MAXPL));
        else if (pick < 70)
          req.payload_len = LEN_W'($urandom_range(MAXPL + 1, MAXPL - 1));
        else if (pick < 75)
          req.payload_len = '0;
        else
          req.payload_len = LEN_W'($urandom_range(16383));
        req.payload_tag = 16'($urandom);
        send_item(req);
      end
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
sv/prd_pkg.sv
sv/prd_ram.sv
sv/prd_ctl.sv
sv/priority_ring_deque_core.sv
tb/tb.sv
